// File: sv/morse_symbol_blink_sequencer_unit_defines.svh
`ifndef MORSE_SYMBOL_BLINK_SEQUENCER_UNIT_DEFINES_SVH
`define MORSE_SYMBOL_BLINK_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("msbs: implication check failed");

// Next-cycle implication, checked outside reset.
`define MSBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("msbs: next-cycle check failed");

`endif

// File: sv/msbs_pkg.sv
`default_nettype none
package msbs_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam logic [15:0] UNIT_MS_RESET = 16'd100;

	localparam logic [1:0] ACT_CHAR  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_PAGE  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [2:0] LED1_BIT = 3'b001;
	localparam logic [2:0] LED2_BIT = 3'b010;
	localparam logic [2:0] LED3_BIT = 3'b100;
	localparam logic [2:0] LED_ALL  = 3'b111;

	typedef struct packed {
		logic load;
		logic emit;
	} msbs_cmd_t;

	typedef struct packed {
		logic in_empty;
		logic seg_last;
	} msbs_sts_t;

	// The pattern is left aligned: bit 6 is the first element, a one is a dash.
	typedef struct packed {
		logic       valid;
		logic [2:0] len;
		logic [6:0] pat;
	} morse_t;

	function automatic morse_t morse_code(input logic [7:0] ch_in);
		logic [7:0] ch;
		morse_t     res;
		ch = ch_in;
		if (ch >= "a" && ch <= "z") begin
			ch = ch - 8'd32;
		end
		res = '{1'b0, 3'd0, 7'b0000000};
		case (ch)
			"A": res = '{1'b1, 3'd2, 7'b0100000};
			"B": res = '{1'b1, 3'd4, 7'b1000000};
			"C": res = '{1'b1, 3'd4, 7'b1010000};
			"D": res = '{1'b1, 3'd3, 7'b1000000};
			"E": res = '{1'b1, 3'd1, 7'b0000000};
			"F": res = '{1'b1, 3'd4, 7'b0010000};
			"G": res = '{1'b1, 3'd3, 7'b1100000};
			"H": res = '{1'b1, 3'd4, 7'b0000000};
			"I": res = '{1'b1, 3'd2, 7'b0000000};
			"J": res = '{1'b1, 3'd4, 7'b0111000};
			"K": res = '{1'b1, 3'd3, 7'b1010000};
			"L": res = '{1'b1, 3'd4, 7'b0100000};
			"M": res = '{1'b1, 3'd2, 7'b1100000};
			"N": res = '{1'b1, 3'd2, 7'b1000000};
			"O": res = '{1'b1, 3'd3, 7'b1110000};
			"P": res = '{1'b1, 3'd4, 7'b0110000};
			"Q": res = '{1'b1, 3'd4, 7'b1101000};
			"R": res = '{1'b1, 3'd3, 7'b0100000};
			"S": res = '{1'b1, 3'd3, 7'b0000000};
			"T": res = '{1'b1, 3'd1, 7'b1000000};
			"U": res = '{1'b1, 3'd3, 7'b0010000};
			"V": res = '{1'b1, 3'd4, 7'b0001000};
			"W": res = '{1'b1, 3'd3, 7'b0110000};
			"X": res = '{1'b1, 3'd4, 7'b1001000};
			"Y": res = '{1'b1, 3'd4, 7'b1011000};
			"Z": res = '{1'b1, 3'd4, 7'b1100000};
			"1": res = '{1'b1, 3'd5, 7'b0111100};
			"2": res = '{1'b1, 3'd5, 7'b0011100};
			"3": res = '{1'b1, 3'd5, 7'b0001100};
			"4": res = '{1'b1, 3'd5, 7'b0000100};
			"5": res = '{1'b1, 3'd5, 7'b0000000};
			"6": res = '{1'b1, 3'd5, 7'b1000000};
			"7": res = '{1'b1, 3'd5, 7'b1100000};
			"8": res = '{1'b1, 3'd5, 7'b1110000};
			"9": res = '{1'b1, 3'd5, 7'b1111000};
			"0": res = '{1'b1, 3'd5, 7'b1111100};
			".": res = '{1'b1, 3'd6, 7'b0101010};
			",": res = '{1'b1, 3'd6, 7'b1100110};
			"?": res = '{1'b1, 3'd6, 7'b0011000};
			"'": res = '{1'b1, 3'd6, 7'b0111100};
			"!": res = '{1'b1, 3'd6, 7'b1010110};
			"/": res = '{1'b1, 3'd5, 7'b1001000};
			"(": res = '{1'b1, 3'd5, 7'b1011000};
			")": res = '{1'b1, 3'd6, 7'b1011010};
			"&": res = '{1'b1, 3'd5, 7'b0100000};
			":": res = '{1'b1, 3'd6, 7'b1110000};
			";": res = '{1'b1, 3'd6, 7'b1010100};
			"=": res = '{1'b1, 3'd5, 7'b1000100};
			"+": res = '{1'b1, 3'd5, 7'b1010100};
			"-": res = '{1'b1, 3'd6, 7'b1000010};
			"_": res = '{1'b1, 3'd6, 7'b0011010};
			"\"": res = '{1'b1, 3'd6, 7'b0100100};
			"$": res = '{1'b1, 3'd7, 7'b0001001};
			"@": res = '{1'b1, 3'd6, 7'b0110100};
			" ": res = '{1'b1, 3'd4, 7'b0000000};
			default: res = '{1'b0, 3'd0, 7'b0000000};
		endcase
		return res;
	endfunction

	// LED order of the start sweep, one entry per pair of toggles.
	function automatic logic [2:0] start_mask(input logic [2:0] pair);
		logic [2:0] m;
		case (pair)
			3'd0:    m = LED1_BIT;
			3'd1:    m = LED2_BIT;
			3'd2:    m = LED3_BIT;
			3'd3:    m = LED2_BIT;
			3'd4:    m = LED1_BIT;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// File: sv/msbs_dp.sv
`default_nettype none
module msbs_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          action,
	input  wire logic [7:0]          char_code,
	input  wire logic [15:0]         unit_ms,
	input  wire msbs_pkg::msbs_cmd_t cmd,
	output msbs_pkg::msbs_sts_t      sts,
	output logic [2:0]               led_levels,
	output logic [2:0]               hold_units,
	output logic [18:0]              hold_ms,
	output logic                     last_segment
);
	import msbs_pkg::*;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_UNK   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_PAGE  = 2'd3;

	localparam logic [3:0] START_SEGS = 4'd11;
	localparam logic [3:0] START_GAP  = 4'd10;
	localparam logic [3:0] PAGE_SEGS  = 4'd4;
	localparam logic [3:0] UNK_SEGS   = 4'd2;

	logic [1:0]  kind_q;
	logic [6:0]  pat_q;
	logic [3:0]  total_q;
	logic [3:0]  step_q;
	logic [2:0]  led_now_q;
	logic [2:0]  led_q;
	logic [2:0]  units_q;
	logic [18:0] ms_q;
	logic        last_q;

	morse_t      code;
	logic [1:0]  kind_d;
	logic [3:0]  total_d;
	logic [2:0]  elem;
	logic [2:0]  mask;
	logic [2:0]  units;
	logic [2:0]  led_next;
	logic [18:0] ms_next;

	always_comb begin
		code = morse_code(char_code);
		kind_d = KIND_CHAR;
		total_d = 4'd0;
		unique case (action)
			ACT_CHAR: begin
				if (code.valid) begin
					kind_d = KIND_CHAR;
					total_d = {code.len, 1'b0};
				end else begin
					kind_d = KIND_UNK;
					total_d = UNK_SEGS;
				end
			end
			ACT_START: begin
				kind_d = KIND_START;
				total_d = START_SEGS;
			end
			ACT_PAGE: begin
				kind_d = KIND_PAGE;
				total_d = PAGE_SEGS;
			end
			ACT_NONE: begin
				kind_d = KIND_CHAR;
				total_d = 4'd0;
			end
			default: begin
				kind_d = KIND_CHAR;
				total_d = 4'd0;
			end
		endcase
	end

	always_comb begin
		elem = step_q[3:1];
		mask = 3'b000;
		units = 3'd1;
		unique case (kind_q)
			KIND_CHAR: begin
				mask = LED2_BIT;
				units = (!step_q[0] && pat_q[3'd6 - elem]) ? 3'd3 : 3'd1;
			end
			KIND_UNK: begin
				mask = LED3_BIT;
				units = 3'd3;
			end
			KIND_START: begin
				if (step_q == START_GAP) begin
					mask = 3'b000;
					units = 3'd7;
				end else begin
					mask = start_mask(elem);
					units = 3'd1;
				end
			end
			KIND_PAGE: begin
				mask = LED_ALL;
				units = 3'd1;
			end
			default: begin
				mask = 3'b000;
				units = 3'd1;
			end
		endcase
		led_next = led_now_q ^ mask;
		ms_next = 19'(units) * 19'(unit_ms);
	end

	assign sts.in_empty = (action == ACT_NONE);
	assign sts.seg_last = (step_q == total_q - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
			led_now_q <= 3'b000;
		end else if (cmd.load) begin
			step_q <= 4'd0;
		end else if (cmd.emit) begin
			step_q <= step_q + 4'd1;
			led_now_q <= led_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_d;
			pat_q <= code.pat;
			total_q <= total_d;
		end
		if (cmd.emit) begin
			led_q <= led_next;
			units_q <= units;
			ms_q <= ms_next;
			last_q <= sts.seg_last;
		end
	end

	assign led_levels = led_q;
	assign hold_units = units_q;
	assign hold_ms = ms_q;
	assign last_segment = last_q;

endmodule
`default_nettype wire

// File: sv/msbs_ctrl.sv
`default_nettype none
`include "morse_symbol_blink_sequencer_unit_defines.svh"
module msbs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	input  wire msbs_pkg::msbs_sts_t sts,
	output msbs_pkg::msbs_cmd_t      cmd
);
	import msbs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.emit = (state_q == ST_RUN) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && !sts.in_empty) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.emit && sts.seg_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`MSBS_ASSERT_NEXT(a_load_starts_run, clk, arst_n, cmd.load && !sts.in_empty, state_q == ST_RUN)
	`MSBS_ASSERT_NEXT(a_last_ends_run, clk, arst_n, cmd.emit && sts.seg_last, (state_q == ST_IDLE) && m_tvalid_q)
	`MSBS_ASSERT_IMPL(a_no_emit_idle, clk, arst_n, state_q == ST_IDLE, !cmd.emit)
	`MSBS_ASSERT_NEXT(a_empty_stays_idle, clk, arst_n, cmd.load && sts.in_empty, (state_q == ST_IDLE) && !cmd.emit)

endmodule
`default_nettype wire

// File: sv/morse_symbol_blink_sequencer_unit.sv
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata: action, char_code
// m_axis    out  m_tvalid/m_tready    m_tdata: led_levels, hold_units, hold_ms; m_tlast
// apb       in   psel/penable/pready  unit_ms at address 0
//
// A command is accepted while the sequencer is idle and then yields N segments,
// N being 0 to 14, one segment per cycle when the output is ready.
// The single-entry output register sets the pace; a stalled output holds the sequencer.
// A new command is taken as soon as the last segment sits in the output register.
// Reset turns all LEDs off and sets unit_ms to 100.
`default_nettype none
module morse_symbol_blink_sequencer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,  // action[1:0], char_code[9:2]
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,  // led_levels[2:0], hold_units[5:3], hold_ms[24:6]
	output logic                             m_tlast,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [msbs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import msbs_pkg::*;

	logic [15:0] unit_ms_q;
	msbs_cmd_t   cmd;
	msbs_sts_t   sts;
	logic [2:0]  led_levels;
	logic [2:0]  hold_units;
	logic [18:0] hold_ms;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, unit_ms_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ms_q <= UNIT_MS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			unit_ms_q <= pwdata[15:0];
		end
	end

	msbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (s_tdata[1:0]),
		.char_code    (s_tdata[9:2]),
		.unit_ms      (unit_ms_q),
		.cmd          (cmd),
		.sts          (sts),
		.led_levels   (led_levels),
		.hold_units   (hold_units),
		.hold_ms      (hold_ms),
		.last_segment (m_tlast)
	);

	assign m_tdata = {7'd0, hold_ms, hold_units, led_levels};

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msbs_pkg::*;

	localparam logic [ADDR_W-1:0] REG_UNIT_MS = '0;
	localparam logic [2:0] HOLD_DOT  = 3'd1;
	localparam logic [2:0] HOLD_DASH = 3'd3;
	localparam logic [2:0] HOLD_GAP  = 3'd7;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD_CYCLES = 300;

	class morse_scoreboard;
		typedef struct packed {
			logic [2:0]  leds;
			logic [2:0]  units;
			logic [18:0] ms;
			logic        last;
		} segment_t;

		segment_t    expected_segments[$];
		logic [2:0]  leds_now;
		logic [15:0] unit_ms;
		int          errors;

		function new();
			leds_now = 3'b000;
			unit_ms = UNIT_MS_RESET;
			errors = 0;
		endfunction

		function int pending();
			return expected_segments.size();
		endfunction

		function string pattern_of(logic [7:0] c);
			logic [7:0] u;
			u = c;
			if (u >= "a" && u <= "z") begin
				u = u - 8'd32;
			end
			case (u)
				"A": return ".-";
				"B": return "-...";
				"C": return "-.-.";
				"D": return "-..";
				"E": return ".";
				"F": return "..-.";
				"G": return "--.";
				"H": return "....";
				"I": return "..";
				"J": return ".---";
				"K": return "-.-";
				"L": return ".-..";
				"M": return "--";
				"N": return "-.";
				"O": return "---";
				"P": return ".--.";
				"Q": return "--.-";
				"R": return ".-.";
				"S": return "...";
				"T": return "-";
				"U": return "..-";
				"V": return "...-";
				"W": return ".--";
				"X": return "-..-";
				"Y": return "-.--";
				"Z": return "--..";
				"1": return ".----";
				"2": return "..---";
				"3": return "...--";
				"4": return "....-";
				"5": return ".....";
				"6": return "-....";
				"7": return "--...";
				"8": return "---..";
				"9": return "----.";
				"0": return "-----";
				".": return ".-.-.-";
				",": return "--..--";
				"?": return "..--..";
				"'": return ".----.";
				"!": return "-.-.--";
				"/": return "-..-.";
				"(": return "-.--.";
				")": return "-.--.-";
				"&": return ".-...";
				":": return "---...";
				";": return "-.-.-.";
				"=": return "-...-";
				"+": return "-.-.-";
				"-": return "-....-";
				"_": return "..--.-";
				"\"": return ".-..-.";
				"$": return "...-..-";
				"@": return ".--.-.";
				" ": return "....";
				default: return "";
			endcase
		endfunction

		function void hold(logic [2:0] units);
			segment_t s;
			logic [31:0] prod;
			prod = 32'(units) * 32'(unit_ms);
			s.leds = leds_now;
			s.units = units;
			s.ms = prod[18:0];
			s.last = 1'b0;
			expected_segments.push_back(s);
		endfunction

		function void toggle_hold(logic [2:0] mask, logic [2:0] units);
			leds_now = leds_now ^ mask;
			hold(units);
		endfunction

		function void note_command(logic [1:0] act, logic [7:0] ch);
			string pat;
			int first;
			logic [2:0] sweep[5];
			first = expected_segments.size();
			sweep = '{LED1_BIT, LED2_BIT, LED3_BIT, LED2_BIT, LED1_BIT};
			case (act)
				ACT_CHAR: begin
					pat = pattern_of(ch);
					if (pat.len() == 0) begin
						toggle_hold(LED3_BIT, HOLD_DASH);
						toggle_hold(LED3_BIT, HOLD_DASH);
					end else begin
						for (int i = 0; i < pat.len(); i++) begin
							toggle_hold(LED2_BIT, (pat[i] == "-") ? HOLD_DASH : HOLD_DOT);
							toggle_hold(LED2_BIT, HOLD_DOT);
						end
					end
				end
				ACT_START: begin
					foreach (sweep[k]) begin
						toggle_hold(sweep[k], HOLD_DOT);
						toggle_hold(sweep[k], HOLD_DOT);
					end
					hold(HOLD_GAP);
				end
				ACT_PAGE: begin
					for (int k = 0; k < 4; k++) begin
						toggle_hold(LED_ALL, HOLD_DOT);
					end
				end
				default: begin
				end
			endcase
			if (expected_segments.size() > first) begin
				expected_segments[expected_segments.size() - 1].last = 1'b1;
			end
		endfunction

		function void check_segment(logic [2:0] leds, logic [2:0] units, logic [18:0] ms,
				logic last);
			segment_t e;
			if (expected_segments.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("unexpected segment: leds=%0d units=%0d ms=%0d last=%0d",
						leds, units, ms, last);
				end
				return;
			end
			e = expected_segments.pop_front();
			if (e.leds !== leds || e.units !== units || e.ms !== ms || e.last !== last) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("segment leds/units/ms/last: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						e.leds, e.units, e.ms, e.last, leds, units, ms, last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bit calm = 1'b0;
	bit long_hold_req = 1'b0;
	string known_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@ ";
	morse_scoreboard sb = new();

	morse_symbol_blink_sequencer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_segment(m_tdata[2:0], m_tdata[5:3], m_tdata[24:6], m_tlast);
			end
			if (s_tvalid && s_tready) begin
				sb.note_command(s_tdata[1:0], s_tdata[9:2]);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_command(input logic [1:0] act, input logic [7:0] ch);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b000000, ch, act};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_segments();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_unit_ms(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_UNIT_MS;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.unit_ms = value;
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		c = known_chars[$urandom_range(0, known_chars.len() - 1)];
		if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
			c = c + 8'd32;
		end
		return c;
	endfunction

	task automatic run_random_commands(input int count);
		int sent;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_command(ACT_CHAR, pick_char());
			end else if (r < 80) begin
				send_command(ACT_CHAR, 8'($urandom_range(0, 255)));
			end else if (r < 88) begin
				send_command(ACT_START, 8'($urandom_range(0, 255)));
			end else if (r < 96) begin
				send_command(ACT_PAGE, 8'($urandom_range(0, 255)));
			end else begin
				send_command(ACT_NONE, 8'($urandom_range(0, 255)));
				sent--;
			end
			sent++;
		end
	endtask

	initial begin
		logic [7:0] directed_chars[16];
		directed_chars = '{"E", "T", "0", "$", "a", "z", " ", "@", "\"", "'", "_", 8'h00,
			8'hFF, 8'h80, "#", 8'h7F};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_chars[i]) begin
			send_command(ACT_CHAR, directed_chars[i]);
		end
		send_command(ACT_START, 8'h00);
		send_command(ACT_PAGE, 8'hFF);
		send_command(ACT_NONE, 8'hFF);
		send_command(ACT_NONE, 8'h00);
		send_command(ACT_START, 8'hFF);
		send_command(ACT_PAGE, 8'h00);
		drain_segments();

		write_unit_ms(16'd1);
		run_random_commands(50);
		drain_segments();

		write_unit_ms(16'hFFFF);
		long_hold_req = 1'b1;
		run_random_commands(60);
		drain_segments();

		write_unit_ms(16'd0);
		run_random_commands(40);
		drain_segments();

		write_unit_ms(16'($urandom_range(2, 65534)));
		run_random_commands(80);
		drain_segments();

		write_unit_ms(UNIT_MS_RESET);
		calm = 1'b1;
		run_random_commands(80);
		drain_segments();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/msbs_pkg.sv
sv/msbs_dp.sv
sv/msbs_ctrl.sv
sv/morse_symbol_blink_sequencer_unit.sv
tb/tb.sv
